@@ sv/eba_pkg.sv @@
// Shared types and constants for the 8-bit ALU with flags.
`default_nettype none

package eba_pkg;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0,
		OP_ADC = 4'd1,
		OP_SUB = 4'd2,
		OP_SBC = 4'd3,
		OP_AND = 4'd4,
		OP_XOR = 4'd5,
		OP_OR  = 4'd6,
		OP_CP  = 4'd7,
		OP_INC = 4'd8,
		OP_DEC = 4'd9,
		OP_DAA = 4'd10,
		OP_CPL = 4'd11
	} op_t;

	localparam logic [7:0] DAA_ADJ_HI = 8'h60;
	localparam logic [7:0] DAA_ADJ_LO = 8'h06;
	localparam logic [7:0] BCD_MAX    = 8'h99;
	localparam logic [3:0] DIGIT_MAX  = 4'h9;
	localparam logic [3:0] NIB_ONES   = 4'hF;
	localparam logic [7:0] BYTE_ONES  = 8'hFF;

	// op stays a raw code so that the unused codes pass through untouched
	typedef struct packed {
		logic [3:0] op;
		logic [7:0] acc;
		logic [7:0] operand;
		logic       zero_in;
		logic       sub_in;
		logic       half_in;
		logic       carry_in;
	} alu_in_t;

	typedef struct packed {
		logic [7:0] result;
		logic       zero_flag;
		logic       sub_flag;
		logic       half_flag;
		logic       carry_flag;
	} alu_out_t;

endpackage

`default_nettype wire

@@ sv/eba_core.sv @@
// Combinational ALU datapath: value and flags for one operation.
`default_nettype none

module eba_core (
	input  eba_pkg::alu_in_t  din,
	output eba_pkg::alu_out_t dout
);

	logic       cin;
	logic [8:0] sum;
	logic [4:0] sum_lo;
	logic [8:0] diff;
	logic [4:0] diff_lo;
	logic [7:0] inc_val;
	logic [7:0] dec_val;
	logic       daa_hi;
	logic       daa_lo;
	logic [7:0] daa_add1;
	logic [7:0] daa_add;
	logic [7:0] daa_sub;
	logic [7:0] daa_val;
	logic [7:0] logic_val;

	always_comb begin
		cin = (din.op == eba_pkg::OP_ADC || din.op == eba_pkg::OP_SBC) ? din.carry_in : 1'b0;
		sum     = {1'b0, din.acc} + {1'b0, din.operand} + {8'd0, cin};
		sum_lo  = {1'b0, din.acc[3:0]} + {1'b0, din.operand[3:0]} + {4'd0, cin};
		// the sign bit of the 9-bit difference is the borrow
		diff    = {1'b0, din.acc} - {1'b0, din.operand} - {8'd0, cin};
		diff_lo = {1'b0, din.acc[3:0]} - {1'b0, din.operand[3:0]} - {4'd0, cin};
		inc_val = din.acc + 8'd1;
		dec_val = din.acc - 8'd1;

		// adding 0x60 leaves the low nibble alone, so both tests look at acc
		daa_hi   = din.carry_in || (din.acc > eba_pkg::BCD_MAX);
		daa_lo   = din.half_in || (din.acc[3:0] > eba_pkg::DIGIT_MAX);
		daa_add1 = daa_hi ? din.acc + eba_pkg::DAA_ADJ_HI : din.acc;
		daa_add  = daa_lo ? daa_add1 + eba_pkg::DAA_ADJ_LO : daa_add1;
		daa_sub  = din.acc - (din.carry_in ? eba_pkg::DAA_ADJ_HI : 8'h00)
			- (din.half_in ? eba_pkg::DAA_ADJ_LO : 8'h00);
		daa_val  = din.sub_in ? daa_sub : daa_add;

		logic_val = 8'h00;
		dout      = '0;
		case (eba_pkg::op_t'(din.op))
			eba_pkg::OP_ADD, eba_pkg::OP_ADC: begin
				dout.result     = sum[7:0];
				dout.zero_flag  = (sum[7:0] == 8'h00);
				dout.sub_flag   = 1'b0;
				dout.half_flag  = sum_lo[4];
				dout.carry_flag = sum[8];
			end
			eba_pkg::OP_SUB, eba_pkg::OP_SBC, eba_pkg::OP_CP: begin
				dout.result     = (din.op == eba_pkg::OP_CP) ? din.acc : diff[7:0];
				dout.zero_flag  = (diff[7:0] == 8'h00);
				dout.sub_flag   = 1'b1;
				dout.half_flag  = diff_lo[4];
				dout.carry_flag = diff[8];
			end
			eba_pkg::OP_AND, eba_pkg::OP_XOR, eba_pkg::OP_OR: begin
				if (din.op == eba_pkg::OP_AND) begin
					logic_val = din.acc & din.operand;
				end else if (din.op == eba_pkg::OP_XOR) begin
					logic_val = din.acc ^ din.operand;
				end else begin
					logic_val = din.acc | din.operand;
				end
				dout.result     = logic_val;
				dout.zero_flag  = (logic_val == 8'h00);
				dout.sub_flag   = 1'b0;
				dout.half_flag  = (din.op == eba_pkg::OP_AND);
				dout.carry_flag = 1'b0;
			end
			eba_pkg::OP_INC: begin
				dout.result     = inc_val;
				dout.zero_flag  = (inc_val == 8'h00);
				dout.sub_flag   = 1'b0;
				dout.half_flag  = (din.acc[3:0] == eba_pkg::NIB_ONES);
				dout.carry_flag = din.carry_in;
			end
			eba_pkg::OP_DEC: begin
				dout.result     = dec_val;
				dout.zero_flag  = (dec_val == 8'h00);
				dout.sub_flag   = 1'b1;
				dout.half_flag  = (din.acc[3:0] == 4'h0);
				dout.carry_flag = din.carry_in;
			end
			eba_pkg::OP_DAA: begin
				dout.result     = daa_val;
				dout.zero_flag  = (daa_val == 8'h00);
				dout.sub_flag   = din.sub_in;
				dout.half_flag  = 1'b0;
				dout.carry_flag = din.sub_in ? din.carry_in : (din.carry_in | daa_hi);
			end
			eba_pkg::OP_CPL: begin
				dout.result     = din.acc ^ eba_pkg::BYTE_ONES;
				dout.zero_flag  = din.zero_in;
				dout.sub_flag   = 1'b1;
				dout.half_flag  = 1'b1;
				dout.carry_flag = din.carry_in;
			end
			default: begin
				// unused codes: no operation
				dout.result     = din.acc;
				dout.zero_flag  = din.zero_in;
				dout.sub_flag   = din.sub_in;
				dout.half_flag  = din.half_in;
				dout.carry_flag = din.carry_in;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ sv/eight_bit_alu_with_flags.sv @@
// 8-bit accumulator ALU with zero, subtract, half-carry and carry flags.
//
// Input channel: in_valid / in_stall carry op, acc, operand and the four
// current flags. Output channel: out_valid / out_stall carry result and the
// four new flags. A transaction completes on a rising edge with valid high
// and stall low.
//
// An item is captured in the input register, the ALU logic works on it
// combinationally, and the result register drives the outputs.
// Throughput is one item per cycle while the receiver keeps out_stall low.
// When the receiver stalls, the result register holds; the input register
// still takes one more item, and in_stall rises only when both registers
// are full and the output is stalled.
//
// Reset (arst_n low, asynchronous) empties both registers; out_valid is low
// until the first item has passed through.
`default_nettype none

module eight_bit_alu_with_flags (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [3:0] op,
	input  logic [7:0] acc,
	input  logic [7:0] operand,
	input  logic       zero_in,
	input  logic       sub_in,
	input  logic       half_in,
	input  logic       carry_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] result,
	output logic       zero_flag,
	output logic       sub_flag,
	output logic       half_flag,
	output logic       carry_flag
);

	logic              valid_s1;
	eba_pkg::alu_in_t  data_s1;
	logic              valid_s2;
	eba_pkg::alu_out_t res_s2;
	eba_pkg::alu_out_t alu_res;
	logic              hold_s2;
	logic              adv_s1;
	logic              take_in;

	assign hold_s2  = valid_s2 && out_stall;
	assign adv_s1   = valid_s1 && !hold_s2;
	assign in_stall = valid_s1 && hold_s2;
	assign take_in  = in_valid && !in_stall;

	eba_core u_core (
		.din  (data_s1),
		.dout (alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (!hold_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			data_s1 <= '{op: op, acc: acc, operand: operand, zero_in: zero_in,
				sub_in: sub_in, half_in: half_in, carry_in: carry_in};
		end
		if (adv_s1) begin
			res_s2 <= alu_res;
		end
	end

	assign out_valid  = valid_s2;
	assign result     = res_s2.result;
	assign zero_flag  = res_s2.zero_flag;
	assign sub_flag   = res_s2.sub_flag;
	assign half_flag  = res_s2.half_flag;
	assign carry_flag = res_s2.carry_flag;

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && out_stall |-> in_stall)
		else $error("input taken while both stages are full and stalled");

	a_fill_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("accepted transaction lost in input stage");

	a_fill_s2: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> out_valid)
		else $error("advanced transaction lost in result stage");

	a_cp_keeps_acc: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && data_s1.op == eba_pkg::OP_CP |=> result == $past(data_s1.acc))
		else $error("compare changed the accumulator");

endmodule

`default_nettype wire

@@ tb/eight_bit_alu_with_flags_tb.sv @@
// Self-checking testbench for the 8-bit ALU with flags: directed table, then random traffic.
`default_nettype none

module eight_bit_alu_with_flags_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [3:0] OP_UNUSED_LO = 4'd12;
	localparam logic [3:0] OP_UNUSED_HI = 4'd15;
	localparam int         RAND_PER_PHASE = 517;
	localparam int         NUM_PHASES     = 3;
	localparam int         QUIET_LIMIT    = 2000;
	localparam int         HOLD_CYCLES    = 64;
	localparam int         HOLD_AFTER     = 150;
	localparam int         MAX_REPORTS    = 10;
	localparam int         DIR_ROWS       = 25;

	// flag nibbles are {zero, sub, half, carry}
	typedef struct packed {
		logic [3:0] op;
		logic [7:0] a;
		logic [7:0] b;
		logic [3:0] fin;
		logic       typed;
		logic [7:0] res;
		logic [3:0] fout;
	} dir_row_t;

	dir_row_t dir_table [DIR_ROWS] = '{
		'{eba_pkg::OP_ADD, 8'hFF, 8'h01, 4'b0000, 1'b1, 8'h00, 4'b1011},
		'{eba_pkg::OP_ADD, 8'h00, 8'h00, 4'b1111, 1'b1, 8'h00, 4'b1000},
		'{eba_pkg::OP_ADC, 8'hFF, 8'h00, 4'b0001, 1'b1, 8'h00, 4'b1011},
		'{eba_pkg::OP_SUB, 8'h00, 8'h01, 4'b0000, 1'b1, 8'hFF, 4'b0111},
		'{eba_pkg::OP_SUB, 8'h55, 8'h55, 4'b0001, 1'b1, 8'h00, 4'b1100},
		'{eba_pkg::OP_SBC, 8'h00, 8'hFF, 4'b0001, 1'b1, 8'h00, 4'b1111},
		'{eba_pkg::OP_AND, 8'hFF, 8'hFF, 4'b0000, 1'b1, 8'hFF, 4'b0010},
		'{eba_pkg::OP_AND, 8'hAA, 8'h55, 4'b0000, 1'b1, 8'h00, 4'b1010},
		'{eba_pkg::OP_XOR, 8'hFF, 8'hFF, 4'b1111, 1'b1, 8'h00, 4'b1000},
		'{eba_pkg::OP_OR,  8'h00, 8'h00, 4'b0000, 1'b1, 8'h00, 4'b1000},
		'{eba_pkg::OP_OR,  8'hF0, 8'h0F, 4'b0000, 1'b1, 8'hFF, 4'b0000},
		'{eba_pkg::OP_CP,  8'h3C, 8'h3C, 4'b0000, 1'b1, 8'h3C, 4'b1100},
		'{eba_pkg::OP_CP,  8'h00, 8'hFF, 4'b1111, 1'b0, 8'h00, 4'b0000},
		'{eba_pkg::OP_INC, 8'hFF, 8'h00, 4'b0001, 1'b1, 8'h00, 4'b1011},
		'{eba_pkg::OP_INC, 8'h0F, 8'hFF, 4'b1110, 1'b0, 8'h00, 4'b0000},
		'{eba_pkg::OP_DEC, 8'h00, 8'h00, 4'b0000, 1'b1, 8'hFF, 4'b0110},
		'{eba_pkg::OP_DEC, 8'h01, 8'hFF, 4'b0001, 1'b1, 8'h00, 4'b1101},
		'{eba_pkg::OP_DAA, 8'h9A, 8'h00, 4'b0000, 1'b1, 8'h00, 4'b1001},
		'{eba_pkg::OP_DAA, 8'h00, 8'h00, 4'b0010, 1'b0, 8'h00, 4'b0000},
		'{eba_pkg::OP_DAA, 8'h0A, 8'h00, 4'b0000, 1'b0, 8'h00, 4'b0000},
		'{eba_pkg::OP_DAA, 8'h00, 8'h00, 4'b0111, 1'b1, 8'h9A, 4'b0101},
		'{eba_pkg::OP_DAA, 8'h45, 8'h00, 4'b0100, 1'b0, 8'h00, 4'b0000},
		'{eba_pkg::OP_CPL, 8'h00, 8'h00, 4'b1001, 1'b1, 8'hFF, 4'b1111},
		'{OP_UNUSED_LO, 8'h5A, 8'hA5, 4'b1111, 1'b1, 8'h5A, 4'b1111},
		'{OP_UNUSED_HI, 8'h00, 8'hFF, 4'b0000, 1'b0, 8'h00, 4'b0000}
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [3:0] op;
	logic [7:0] acc;
	logic [7:0] operand;
	logic       zero_in;
	logic       sub_in;
	logic       half_in;
	logic       carry_in;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] result;
	logic       zero_flag;
	logic       sub_flag;
	logic       half_flag;
	logic       carry_flag;

	eba_pkg::alu_out_t expected_q [$];
	int       fail_count = 0;
	int       items_in = 0;
	int       results_out = 0;
	int       send_idle_pct = 19;
	int       recv_idle_pct = 66;

	eight_bit_alu_with_flags dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.acc        (acc),
		.operand    (operand),
		.zero_in    (zero_in),
		.sub_in     (sub_in),
		.half_in    (half_in),
		.carry_in   (carry_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.result     (result),
		.zero_flag  (zero_flag),
		.sub_flag   (sub_flag),
		.half_flag  (half_flag),
		.carry_flag (carry_flag)
	);

	always #5 clk = ~clk;

	function automatic eba_pkg::alu_out_t alu_predict(input eba_pkg::alu_in_t it);
		eba_pkg::alu_out_t o;
		logic       cin;
		logic [8:0] wide;
		logic [4:0] nib;
		logic [7:0] r;
		logic       c;
		o = '{result: it.acc, zero_flag: it.zero_in, sub_flag: it.sub_in,
			half_flag: it.half_in, carry_flag: it.carry_in};
		case (it.op)
			eba_pkg::OP_ADD, eba_pkg::OP_ADC: begin
				cin = (it.op == eba_pkg::OP_ADC) ? it.carry_in : 1'b0;
				wide = {1'b0, it.acc} + {1'b0, it.operand} + {8'd0, cin};
				nib = {1'b0, it.acc[3:0]} + {1'b0, it.operand[3:0]} + {4'd0, cin};
				o = '{wide[7:0], wide[7:0] == 8'h00, 1'b0, nib[4], wide[8]};
			end
			eba_pkg::OP_SUB, eba_pkg::OP_SBC, eba_pkg::OP_CP: begin
				cin = (it.op == eba_pkg::OP_SBC) ? it.carry_in : 1'b0;
				r = it.acc - it.operand - {7'd0, cin};
				nib = {1'b0, it.operand[3:0]} + {4'd0, cin};
				wide = {1'b0, it.operand} + {8'd0, cin};
				o.result = (it.op == eba_pkg::OP_CP) ? it.acc : r;
				o.zero_flag = (r == 8'h00);
				o.sub_flag = 1'b1;
				o.half_flag = {1'b0, it.acc[3:0]} < nib;
				o.carry_flag = {1'b0, it.acc} < wide;
			end
			eba_pkg::OP_AND: begin
				r = it.acc & it.operand;
				o = '{r, r == 8'h00, 1'b0, 1'b1, 1'b0};
			end
			eba_pkg::OP_XOR: begin
				r = it.acc ^ it.operand;
				o = '{r, r == 8'h00, 1'b0, 1'b0, 1'b0};
			end
			eba_pkg::OP_OR: begin
				r = it.acc | it.operand;
				o = '{r, r == 8'h00, 1'b0, 1'b0, 1'b0};
			end
			eba_pkg::OP_INC: begin
				r = it.acc + 8'd1;
				o = '{r, r == 8'h00, 1'b0, it.acc[3:0] == eba_pkg::NIB_ONES, it.carry_in};
			end
			eba_pkg::OP_DEC: begin
				r = it.acc - 8'd1;
				o = '{r, r == 8'h00, 1'b1, it.acc[3:0] == 4'h0, it.carry_in};
			end
			eba_pkg::OP_DAA: begin
				r = it.acc;
				c = it.carry_in;
				if (it.sub_in) begin
					if (it.carry_in)
						r = r - eba_pkg::DAA_ADJ_HI;
					if (it.half_in)
						r = r - eba_pkg::DAA_ADJ_LO;
				end else begin
					if (it.carry_in || r > eba_pkg::BCD_MAX) begin
						r = r + eba_pkg::DAA_ADJ_HI;
						c = 1'b1;
					end
					if (it.half_in || r[3:0] > eba_pkg::DIGIT_MAX)
						r = r + eba_pkg::DAA_ADJ_LO;
				end
				o = '{r, r == 8'h00, it.sub_in, 1'b0, c};
			end
			eba_pkg::OP_CPL: begin
				o = '{it.acc ^ eba_pkg::BYTE_ONES, it.zero_in, 1'b1, 1'b1, it.carry_in};
			end
			default: ;
		endcase
		return o;
	endfunction

	// lean toward bytes at nibble and BCD boundaries
	function automatic logic [7:0] pick_byte();
		logic [7:0] corners [8] = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h99, 8'h9A, 8'h80, 8'h7F};
		if ($urandom_range(99) < 30)
			return corners[$urandom_range(7)];
		return 8'($urandom);
	endfunction

	function automatic eba_pkg::alu_in_t random_item();
		eba_pkg::alu_in_t it;
		if ($urandom_range(99) < 90)
			it.op = 4'($urandom_range(eba_pkg::OP_CPL));
		else
			it.op = 4'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
		it.acc = pick_byte();
		it.operand = pick_byte();
		{it.zero_in, it.sub_in, it.half_in, it.carry_in} = 4'($urandom);
		return it;
	endfunction

	function automatic void note_fail(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("[%0t] %s", $realtime, msg);
	endfunction

	// offer one transaction, hold it until accepted, then record its expectation
	task automatic send_alu_op(input eba_pkg::alu_in_t it, input logic typed,
			input eba_pkg::alu_out_t want);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op       <= it.op;
		acc      <= it.acc;
		operand  <= it.operand;
		zero_in  <= it.zero_in;
		sub_in   <= it.sub_in;
		half_in  <= it.half_in;
		carry_in <= it.carry_in;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_in++;
		expected_q.push_back(typed ? want : alu_predict(it));
	endtask

	// receiver: random stalls, plus one long hold to back up the pipeline
	initial begin
		logic held;
		held = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && results_out >= HOLD_AFTER) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1)
					@(negedge clk);
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		eba_pkg::alu_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_out++;
			if (expected_q.size() == 0) begin
				note_fail($sformatf("result %02h with no transaction pending", result));
			end else begin
				want = expected_q.pop_front();
				if (result !== want.result || zero_flag !== want.zero_flag ||
						sub_flag !== want.sub_flag || half_flag !== want.half_flag ||
						carry_flag !== want.carry_flag)
					note_fail($sformatf(
						"mismatch: expected %02h znhc=%b%b%b%b, got %02h znhc=%b%b%b%b",
						want.result, want.zero_flag, want.sub_flag, want.half_flag,
						want.carry_flag, result, zero_flag, sub_flag, half_flag,
						carry_flag));
			end
		end
	end

	// watchdog: end the run if nothing moves on either channel for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
		$display("FAILURE");
		$finish;
	end

	initial begin
		eba_pkg::alu_in_t  it;
		eba_pkg::alu_out_t want;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		op       = '0;
		acc      = '0;
		operand  = '0;
		zero_in  = 1'b0;
		sub_in   = 1'b0;
		half_in  = 1'b0;
		carry_in = 1'b0;
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_table[i]) begin
			it = '{dir_table[i].op, dir_table[i].a, dir_table[i].b, dir_table[i].fin[3],
				dir_table[i].fin[2], dir_table[i].fin[1], dir_table[i].fin[0]};
			want = '{dir_table[i].res, dir_table[i].fout[3], dir_table[i].fout[2],
				dir_table[i].fout[1], dir_table[i].fout[0]};
			send_alu_op(it, dir_table[i].typed, want);
		end

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: begin send_idle_pct = 19; recv_idle_pct = 66; end
				1: begin send_idle_pct = 66; recv_idle_pct = 19; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			repeat (RAND_PER_PHASE)
				send_alu_op(random_item(), 1'b0, '0);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
		if (expected_q.size() != 0)
			note_fail($sformatf("%0d results never arrived", expected_q.size()));

		$display("Covered %0d transactions in and %0d out: all ALU ops and unused codes,",
			items_in, results_out);
		$display("three stall/idle profiles and one long output hold; %0d failures",
			fail_count);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

@@ sim.f @@
sv/eba_pkg.sv
sv/eba_core.sv
sv/eight_bit_alu_with_flags.sv
tb/eight_bit_alu_with_flags_tb.sv
